@@ rtl/core/hez_pkg.sv @@
// Shared widths, constants, item types and helpers for the Hermite edge zero-crossing pipeline.
// No dependencies; every other file of the block imports this package.
package hez_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int BISECT_STEPS = 10;
	localparam int INW          = 24;
	localparam int SW           = FRAC_BITS + 1;
	localparam int AW           = INW + 3;
	localparam int BW           = INW + 4;
	localparam int VW           = INW + 8;
	localparam int OUTW         = 17;
	localparam int PRODW        = 2 * INW;
	localparam int DISCW        = 2 * BW;
	localparam int NSQ          = DISCW / 2;
	localparam int RTW          = NSQ;
	localparam int NUMW         = BW + 2;
	localparam int MW           = NUMW - 1 + FRAC_BITS;
	localparam int CMPW         = NUMW - 1 + SW;

	localparam logic [SW-1:0]   ONE      = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [OUTW-1:0] HALF_POS = OUTW'(32768);

	typedef struct packed {
		logic signed [AW-1:0]  a;
		logic signed [BW-1:0]  b;
		logic signed [INW-1:0] c;
		logic signed [INW-1:0] d;
	} coef_t;

	typedef struct packed {
		coef_t coef;
		logic  cand;
		logic  eq;
	} side_t;

	typedef struct packed {
		logic [SW-1:0]        sl;
		logic [SW-1:0]        sr;
		logic signed [VW-1:0] vsl;
		logic                 mid;
		logic                 eq;
	} ctx_t;

	// True when p is nonzero and q is zero or of the opposite sign.
	function automatic logic opposite(logic signed [VW-1:0] p, logic signed [VW-1:0] q);
		return ((p < 0) && (q >= 0)) || ((p > 0) && (q <= 0));
	endfunction

endpackage

@@ rtl/core/hermite_edge_zero_crossing.sv @@
// Channel   Handshake            Fields
// input     start (busy = 0)     value_start, value_end, edge_x/y/z, grad_start_x/y/z, grad_end_x/y/z
// result    done (one cycle)     crossing_pos, middle_root
//
// One transaction enters per cycle and passes through the pipeline
// (5 coefficient stages, 29 square-root stages, 19 divider stages, 3 for the extrema
// values, 1 selection stage, 4 per bisection step for 10 steps, 1 output register).
// The square root (one bit per stage) and the fixed bisection chain make up most of those stages.
// arst_n clears only the valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline never stops and busy is always low.
//
// Depends on hez_pkg, hez_coef, hez_sqrt, hez_div, hez_cubic and hez_bisect.
module hermite_edge_zero_crossing import hez_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [INW-1:0] value_start,
	input  logic signed [INW-1:0] value_end,
	input  logic signed [INW-1:0] edge_x,
	input  logic signed [INW-1:0] edge_y,
	input  logic signed [INW-1:0] edge_z,
	input  logic signed [INW-1:0] grad_start_x,
	input  logic signed [INW-1:0] grad_start_y,
	input  logic signed [INW-1:0] grad_start_z,
	input  logic signed [INW-1:0] grad_end_x,
	input  logic signed [INW-1:0] grad_end_y,
	input  logic signed [INW-1:0] grad_end_z,
	output logic                  done,
	output logic [OUTW-1:0]       crossing_pos,
	output logic                  middle_root
);

	localparam int RSH = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int LSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	// Every stage advances each cycle, so a new transaction is always taken.
	assign busy = 1'b0;

	logic             cf_vld;
	side_t            cf_side;
	logic [DISCW-1:0] cf_disc;

	hez_coef u_coef (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (start),
		.value_start  (value_start),
		.value_end    (value_end),
		.edge_x       (edge_x),
		.edge_y       (edge_y),
		.edge_z       (edge_z),
		.grad_start_x (grad_start_x),
		.grad_start_y (grad_start_y),
		.grad_start_z (grad_start_z),
		.grad_end_x   (grad_end_x),
		.grad_end_y   (grad_end_y),
		.grad_end_z   (grad_end_z),
		.out_vld      (cf_vld),
		.side         (cf_side),
		.disc         (cf_disc)
	);

	logic           sq_vld;
	side_t          sq_side;
	logic [RTW-1:0] sq_root;

	hez_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (cf_vld),
		.side_in  (cf_side),
		.disc_in  (cf_disc),
		.out_vld  (sq_vld),
		.side_out (sq_side),
		.root     (sq_root)
	);

	logic          dv_vld;
	side_t         dv_side;
	logic [SW-1:0] dv_r1, dv_r2;
	logic          dv_ok1, dv_ok2;

	hez_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.side_in  (sq_side),
		.root     (sq_root),
		.out_vld  (dv_vld),
		.side_out (dv_side),
		.r1       (dv_r1),
		.r2       (dv_r2),
		.ok1      (dv_ok1),
		.ok2      (dv_ok2)
	);

	// The first lane carries both extrema in its context and flags whether both
	// fell inside the edge; the second lane only evaluates the cubic at r2.
	ctx_t ex_ctx;
	assign ex_ctx = '{sl: dv_r1, sr: dv_r2, vsl: '0,
		mid: dv_side.cand && dv_ok1 && dv_ok2, eq: dv_side.eq};

	logic                 e1_vld;
	coef_t                e1_coef;
	ctx_t                 e1_ctx;
	logic signed [VW-1:0] e1_val, e2_val;

	hez_cubic u_ext1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (dv_vld),
		.coef_in  (dv_side.coef),
		.s_in     (dv_r1),
		.ctx_in   (ex_ctx),
		.out_vld  (e1_vld),
		.coef_out (e1_coef),
		.s_out    (),
		.ctx_out  (e1_ctx),
		.value    (e1_val)
	);

	hez_cubic u_ext2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (dv_vld),
		.coef_in  (dv_side.coef),
		.s_in     (dv_r2),
		.ctx_in   ('0),
		.out_vld  (),
		.coef_out (),
		.s_out    (),
		.ctx_out  (),
		.value    (e2_val)
	);

	// Selection stage: narrow to the span between the extrema when the cubic
	// changes sign between them, otherwise search the whole edge.
	logic  vld_s1;
	coef_t coef_s1;
	ctx_t  ctx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= e1_vld;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1    <= e1_coef;
		ctx_s1.eq  <= e1_ctx.eq;
		if (e1_ctx.mid && opposite(e1_val, e2_val)) begin
			ctx_s1.mid <= 1'b1;
			if (e1_ctx.sl < e1_ctx.sr) begin
				ctx_s1.sl  <= e1_ctx.sl;
				ctx_s1.vsl <= e1_val;
				ctx_s1.sr  <= e1_ctx.sr;
			end else begin
				ctx_s1.sl  <= e1_ctx.sr;
				ctx_s1.vsl <= e2_val;
				ctx_s1.sr  <= e1_ctx.sl;
			end
		end else begin
			ctx_s1.mid <= 1'b0;
			ctx_s1.sl  <= '0;
			ctx_s1.sr  <= ONE;
			ctx_s1.vsl <= VW'(e1_coef.d);
		end
	end

	// Fixed chain of bisection steps.
	logic  bs_vld  [BISECT_STEPS+1];
	coef_t bs_coef [BISECT_STEPS+1];
	ctx_t  bs_ctx  [BISECT_STEPS+1];

	assign bs_vld[0]  = vld_s1;
	assign bs_coef[0] = coef_s1;
	assign bs_ctx[0]  = ctx_s1;

	for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_step
		hez_bisect u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (bs_vld[i]),
			.coef_in  (bs_coef[i]),
			.ctx_in   (bs_ctx[i]),
			.out_vld  (bs_vld[i+1]),
			.coef_out (bs_coef[i+1]),
			.ctx_out  (bs_ctx[i+1])
		);
	end

	// Output register: midpoint of the final interval, rescaled to 16 fraction bits.
	// Equal end values bypass the search and report the edge midpoint.
	ctx_t        fin;
	logic [SW:0] fin_sum;
	logic [31:0] fin_pos;
	logic        done_s2;
	logic [OUTW-1:0] pos_s2;
	logic        mid_s2;

	assign fin     = bs_ctx[BISECT_STEPS];
	assign fin_sum = {1'b0, fin.sl} + {1'b0, fin.sr};
	assign fin_pos = 32'(fin_sum[SW:1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= bs_vld[BISECT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (fin.eq) begin
			pos_s2 <= HALF_POS;
			mid_s2 <= 1'b0;
		end else begin
			pos_s2 <= OUTW'((fin_pos >> RSH) << LSH);
			mid_s2 <= fin.mid;
		end
	end

	assign done         = done_s2;
	assign crossing_pos = pos_s2;
	assign middle_root  = mid_s2;

endmodule

@@ rtl/core/hez_coef.sv @@
// Front stages: edge derivatives, Hermite cubic coefficients and derivative discriminant.
// Depends on hez_pkg.
module hez_coef import hez_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic signed [INW-1:0] value_start,
	input  logic signed [INW-1:0] value_end,
	input  logic signed [INW-1:0] edge_x,
	input  logic signed [INW-1:0] edge_y,
	input  logic signed [INW-1:0] edge_z,
	input  logic signed [INW-1:0] grad_start_x,
	input  logic signed [INW-1:0] grad_start_y,
	input  logic signed [INW-1:0] grad_start_z,
	input  logic signed [INW-1:0] grad_end_x,
	input  logic signed [INW-1:0] grad_end_y,
	input  logic signed [INW-1:0] grad_end_z,
	output logic                  out_vld,
	output side_t                 side,
	output logic [DISCW-1:0]      disc
);

	localparam int SUMW = PRODW + 2;
	localparam int ACW  = AW + INW;
	localparam int DXW  = DISCW + 2;
	localparam logic signed [SUMW-1:0] MAXV = SUMW'(8388607);
	localparam logic signed [SUMW-1:0] MINV = -MAXV - SUMW'(1);

	// Floor shift by the fraction width, then clamp to the input range.
	function automatic logic signed [INW-1:0] sat_shift(logic signed [SUMW-1:0] x);
		logic signed [SUMW-1:0] sh;
		sh = x >>> FRAC_BITS;
		if (sh > MAXV) begin
			return MAXV[INW-1:0];
		end else if (sh < MINV) begin
			return MINV[INW-1:0];
		end
		return sh[INW-1:0];
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [INW-1:0]   v0_s1, v1_s1, v0_s2, v1_s2;
	logic signed [PRODW-1:0] prod_s1 [6];
	logic signed [INW-1:0]   d0_s2, d1_s2;
	coef_t                   coef_s3, coef_s4;
	logic                    eq_s3, eq_s4;
	logic signed [DISCW-1:0] bb_s4;
	logic signed [ACW-1:0]   ac_s4;
	side_t                   side_s5;
	logic [DISCW-1:0]        disc_s5;

	logic signed [AW-1:0]  dva;
	logic signed [BW-1:0]  dvb;
	logic signed [DXW-1:0] dx;

	assign dva = AW'(v0_s2) - AW'(v1_s2);
	assign dvb = BW'(v1_s2) - BW'(v0_s2);
	assign dx  = (DXW'(bb_s4) <<< 2) - (DXW'(ac_s4) <<< 3) - (DXW'(ac_s4) <<< 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		v0_s1      <= value_start;
		v1_s1      <= value_end;
		prod_s1[0] <= PRODW'(edge_x) * PRODW'(grad_start_x);
		prod_s1[1] <= PRODW'(edge_y) * PRODW'(grad_start_y);
		prod_s1[2] <= PRODW'(edge_z) * PRODW'(grad_start_z);
		prod_s1[3] <= PRODW'(edge_x) * PRODW'(grad_end_x);
		prod_s1[4] <= PRODW'(edge_y) * PRODW'(grad_end_y);
		prod_s1[5] <= PRODW'(edge_z) * PRODW'(grad_end_z);

		v0_s2 <= v0_s1;
		v1_s2 <= v1_s1;
		d0_s2 <= sat_shift(SUMW'(prod_s1[0]) + SUMW'(prod_s1[1]) + SUMW'(prod_s1[2]));
		d1_s2 <= sat_shift(SUMW'(prod_s1[3]) + SUMW'(prod_s1[4]) + SUMW'(prod_s1[5]));

		coef_s3.a <= (dva <<< 1) + AW'(d0_s2) + AW'(d1_s2);
		coef_s3.b <= (dvb <<< 1) + dvb - (BW'(d0_s2) <<< 1) - BW'(d1_s2);
		coef_s3.c <= d0_s2;
		coef_s3.d <= v0_s2;
		eq_s3     <= (v0_s2 == v1_s2);

		coef_s4 <= coef_s3;
		eq_s4   <= eq_s3;
		bb_s4   <= DISCW'(coef_s3.b) * DISCW'(coef_s3.b);
		ac_s4   <= ACW'(coef_s3.a) * ACW'(coef_s3.c);

		side_s5.coef <= coef_s4;
		side_s5.eq   <= eq_s4;
		side_s5.cand <= (dx > 0) && (coef_s4.a != '0);
		disc_s5      <= ((dx > 0) && (coef_s4.a != '0)) ? dx[DISCW-1:0] : '0;
	end

	assign out_vld = vld_s5;
	assign side    = side_s5;
	assign disc    = disc_s5;

endmodule

@@ rtl/core/hez_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, rounded down.
// Depends on hez_pkg.
module hez_sqrt import hez_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  side_t            side_in,
	input  logic [DISCW-1:0] disc_in,
	output logic             out_vld,
	output side_t            side_out,
	output logic [RTW-1:0]   root
);

	logic             vld_s  [NSQ+1];
	side_t            side_s [NSQ+1];
	logic [DISCW-1:0] x_s    [NSQ+1];
	logic [DISCW-1:0] r_s    [NSQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSQ; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= NSQ; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [DISCW-1:0] bitv;
		logic [DISCW-1:0] trial;
		x_s[0]    <= disc_in;
		r_s[0]    <= '0;
		side_s[0] <= side_in;
		for (int k = 1; k <= NSQ; k++) begin
			bitv  = DISCW'(1) << (2 * (NSQ - k));
			trial = r_s[k-1] + bitv;
			if (x_s[k-1] >= trial) begin
				x_s[k] <= x_s[k-1] - trial;
				r_s[k] <= (r_s[k-1] >> 1) + bitv;
			end else begin
				x_s[k] <= x_s[k-1];
				r_s[k] <= r_s[k-1] >> 1;
			end
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_vld  = vld_s[NSQ];
	assign side_out = side_s[NSQ];
	assign root     = r_s[NSQ][RTW-1:0];

endmodule

@@ rtl/core/hez_div.sv @@
// Two-lane pipelined divider for the extrema of the cubic, with the unit-interval check.
// Depends on hez_pkg.
module hez_div import hez_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  side_t          side_in,
	input  logic [RTW-1:0] root,
	output logic           out_vld,
	output side_t          side_out,
	output logic [SW-1:0]  r1,
	output logic [SW-1:0]  r2,
	output logic           ok1,
	output logic           ok2
);

	logic signed [NUMW-1:0] b_x, rt_x, a_x, n1, n2, dn;
	logic [NUMW-2:0]        n1m, n2m, dnm;
	logic [CMPW-1:0]        dlim;

	assign b_x  = NUMW'(side_in.coef.b);
	assign a_x  = NUMW'(side_in.coef.a);
	assign rt_x = signed'(NUMW'(root));
	assign n1   = rt_x - (b_x <<< 1);
	assign n2   = -(b_x <<< 1) - rt_x;
	assign dn   = (a_x <<< 2) + (a_x <<< 1);
	assign n1m  = n1[NUMW-1] ? (NUMW-1)'(-n1) : n1[NUMW-2:0];
	assign n2m  = n2[NUMW-1] ? (NUMW-1)'(-n2) : n2[NUMW-2:0];
	assign dnm  = dn[NUMW-1] ? (NUMW-1)'(-dn) : dn[NUMW-2:0];
	assign dlim = CMPW'(dnm) << SW;

	logic              vld_s  [SW+1];
	side_t             side_s [SW+1];
	logic [NUMW-2:0]   dm_s   [SW+1];
	logic [MW-1:0]     rem_s  [SW+1][2];
	logic [SW-1:0]     q_s    [SW+1][2];
	logic              neg_s  [SW+1][2];
	logic              ovf_s  [SW+1][2];
	logic              vld_f;
	side_t             side_f;
	logic [SW-1:0]     r_f    [2];
	logic              ok_f   [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SW; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_f <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= SW; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			vld_f <= vld_s[SW];
		end
	end

	always_ff @(posedge clk) begin
		logic [CMPW-1:0] trial;
		side_s[0]    <= side_in;
		dm_s[0]      <= dnm;
		rem_s[0][0]  <= {n1m, {FRAC_BITS{1'b0}}};
		rem_s[0][1]  <= {n2m, {FRAC_BITS{1'b0}}};
		q_s[0][0]    <= '0;
		q_s[0][1]    <= '0;
		neg_s[0][0]  <= n1[NUMW-1] ^ dn[NUMW-1];
		neg_s[0][1]  <= n2[NUMW-1] ^ dn[NUMW-1];
		ovf_s[0][0]  <= CMPW'({n1m, {FRAC_BITS{1'b0}}}) >= dlim;
		ovf_s[0][1]  <= CMPW'({n2m, {FRAC_BITS{1'b0}}}) >= dlim;
		for (int k = 1; k <= SW; k++) begin
			side_s[k] <= side_s[k-1];
			dm_s[k]   <= dm_s[k-1];
			trial = CMPW'(dm_s[k-1]) << (SW - k);
			for (int l = 0; l < 2; l++) begin
				neg_s[k][l] <= neg_s[k-1][l];
				ovf_s[k][l] <= ovf_s[k-1][l];
				if (CMPW'(rem_s[k-1][l]) >= trial) begin
					rem_s[k][l] <= rem_s[k-1][l] - MW'(trial);
					q_s[k][l]   <= q_s[k-1][l] | (SW'(1) << (SW - k));
				end else begin
					rem_s[k][l] <= rem_s[k-1][l];
					q_s[k][l]   <= q_s[k-1][l];
				end
			end
		end
		side_f <= side_s[SW];
		for (int l = 0; l < 2; l++) begin
			r_f[l]  <= q_s[SW][l];
			ok_f[l] <= !ovf_s[SW][l] && !(neg_s[SW][l] && (q_s[SW][l] != '0))
				&& (q_s[SW][l] <= ONE);
		end
	end

	assign out_vld  = vld_f;
	assign side_out = side_f;
	assign r1       = r_f[0];
	assign r2       = r_f[1];
	assign ok1      = ok_f[0];
	assign ok2      = ok_f[1];

endmodule

@@ rtl/core/hez_cubic.sv @@
// Three-stage evaluation of the Hermite cubic at one position, with floor rounding per product.
// Depends on hez_pkg.
module hez_cubic import hez_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  coef_t                coef_in,
	input  logic [SW-1:0]        s_in,
	input  ctx_t                 ctx_in,
	output logic                 out_vld,
	output coef_t                coef_out,
	output logic [SW-1:0]        s_out,
	output ctx_t                 ctx_out,
	output logic signed [VW-1:0] value
);

	localparam int PW1 = AW + SW + 1;
	localparam int PW2 = VW + SW + 1;

	logic                  vld_s1, vld_s2, vld_s3;
	coef_t                 coef_s1, coef_s2, coef_s3;
	ctx_t                  ctx_s1, ctx_s2, ctx_s3;
	logic [SW-1:0]         s_s1, s_s2, s_s3;
	logic signed [PW1-1:0] p1_s1;
	logic signed [PW2-1:0] p2_s2, p3_s3;
	logic signed [VW-1:0]  t1, t2;

	assign t1 = VW'(p1_s1 >>> FRAC_BITS) + VW'(coef_s1.b);
	assign t2 = VW'(p2_s2 >>> FRAC_BITS) + VW'(coef_s2.c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= coef_in;
		ctx_s1  <= ctx_in;
		s_s1    <= s_in;
		p1_s1   <= PW1'(coef_in.a) * signed'(PW1'(s_in));
		coef_s2 <= coef_s1;
		ctx_s2  <= ctx_s1;
		s_s2    <= s_s1;
		p2_s2   <= PW2'(t1) * signed'(PW2'(s_s1));
		coef_s3 <= coef_s2;
		ctx_s3  <= ctx_s2;
		s_s3    <= s_s2;
		p3_s3   <= PW2'(t2) * signed'(PW2'(s_s2));
	end

	assign out_vld  = vld_s3;
	assign coef_out = coef_s3;
	assign s_out    = s_s3;
	assign ctx_out  = ctx_s3;
	assign value    = VW'(p3_s3 >>> FRAC_BITS) + VW'(coef_s3.d);

endmodule

@@ rtl/core/hez_bisect.sv @@
// One bisection step: midpoint, cubic evaluation and interval update, four stages.
// Depends on hez_pkg and hez_cubic.
module hez_bisect import hez_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_vld,
	input  coef_t coef_in,
	input  ctx_t  ctx_in,
	output logic  out_vld,
	output coef_t coef_out,
	output ctx_t  ctx_out
);

	logic [SW:0]          sum;
	logic                 vld_c;
	coef_t                coef_c;
	logic [SW-1:0]        sm_c;
	ctx_t                 ctx_c;
	logic signed [VW-1:0] vm;
	logic                 vld_s4;
	coef_t                coef_s4;
	ctx_t                 ctx_s4;

	assign sum = {1'b0, ctx_in.sl} + {1'b0, ctx_in.sr};

	hez_cubic u_cubic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (in_vld),
		.coef_in  (coef_in),
		.s_in     (sum[SW:1]),
		.ctx_in   (ctx_in),
		.out_vld  (vld_c),
		.coef_out (coef_c),
		.s_out    (sm_c),
		.ctx_out  (ctx_c),
		.value    (vm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		coef_s4    <= coef_c;
		ctx_s4.mid <= ctx_c.mid;
		ctx_s4.eq  <= ctx_c.eq;
		if (opposite(ctx_c.vsl, vm)) begin
			ctx_s4.sl  <= ctx_c.sl;
			ctx_s4.vsl <= ctx_c.vsl;
			ctx_s4.sr  <= sm_c;
		end else begin
			ctx_s4.sl  <= sm_c;
			ctx_s4.vsl <= vm;
			ctx_s4.sr  <= ctx_c.sr;
		end
	end

	assign out_vld  = vld_s4;
	assign coef_out = coef_s4;
	assign ctx_out  = ctx_s4;

endmodule
